// ===== src/tald_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tald_pkg;

   localparam int TableLen = 24;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_PREP,
      ST_ROTATE,
      ST_SCALE,
      ST_FILTER,
      ST_READ,
      ST_SUM,
      ST_DIVIDE,
      ST_JUDGE,
      ST_CLEAR
   } state_type;

   localparam logic [2:0] RegRollBase  = 3'd0;
   localparam logic [2:0] RegPitchBase = 3'd1;
   localparam logic [2:0] RegLevel     = 3'd2;
   localparam logic [2:0] RegNear      = 3'd3;
   localparam logic [2:0] RegPulse     = 3'd4;
   localparam logic [2:0] RegAlpha     = 3'd5;

   typedef struct packed {
      logic signed [15:0] roll_baseline;
      logic signed [15:0] pitch_baseline;
      logic [14:0] level_band;
      logic [14:0] near_band;
      logic [14:0] pulse_band;
      logic [15:0] filter_alpha;
   } cfg_type;

   function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
      logic signed [31:0] v;
      case (i)
         5'd0: v = 32'sd2949120;
         5'd1: v = 32'sd1740967;
         5'd2: v = 32'sd919879;
         5'd3: v = 32'sd466945;
         5'd4: v = 32'sd234379;
         5'd5: v = 32'sd117304;
         5'd6: v = 32'sd58666;
         5'd7: v = 32'sd29335;
         5'd8: v = 32'sd14668;
         5'd9: v = 32'sd7334;
         5'd10: v = 32'sd3667;
         5'd11: v = 32'sd1833;
         5'd12: v = 32'sd917;
         5'd13: v = 32'sd458;
         5'd14: v = 32'sd229;
         5'd15: v = 32'sd115;
         5'd16: v = 32'sd57;
         5'd17: v = 32'sd29;
         5'd18: v = 32'sd14;
         5'd19: v = 32'sd7;
         5'd20: v = 32'sd4;
         5'd21: v = 32'sd2;
         5'd22: v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== src/tald_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface tald_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   modport source(output valid, accel_x, accel_y, accel_z, input ready);
   modport sink(input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface tald_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] roll_deviation;
   logic signed [15:0] pitch_deviation;
   logic roll_is_level;
   logic roll_is_near;
   logic roll_wants_pulse;
   logic roll_tilt_positive;
   logic pitch_is_level;
   logic pitch_is_near;
   logic pitch_wants_pulse;
   logic pitch_tilt_positive;
   modport source(output valid, roll_deviation, pitch_deviation, roll_is_level, roll_is_near,
      roll_wants_pulse, roll_tilt_positive, pitch_is_level, pitch_is_near, pitch_wants_pulse,
      pitch_tilt_positive, input ready);
   modport sink(input valid, roll_deviation, pitch_deviation, roll_is_level, roll_is_near,
      roll_wants_pulse, roll_tilt_positive, pitch_is_level, pitch_is_near, pitch_wants_pulse,
      pitch_tilt_positive, output ready);
endinterface
`default_nettype wire

// ===== src/tald_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tald_csr
   import tald_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output cfg_type          cfg
);
   cfg_type cfg_ff, cfg_in;
   logic [2:0] index;

   assign index = paddr[4:2];
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (index)
            RegRollBase: cfg_in.roll_baseline = pwdata[15:0];
            RegPitchBase: cfg_in.pitch_baseline = pwdata[15:0];
            RegLevel: cfg_in.level_band = pwdata[14:0];
            RegNear: cfg_in.near_band = pwdata[14:0];
            RegPulse: cfg_in.pulse_band = pwdata[14:0];
            RegAlpha: cfg_in.filter_alpha = pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         RegRollBase: prdata = {{16{cfg_ff.roll_baseline[15]}}, cfg_ff.roll_baseline};
         RegPitchBase: prdata = {{16{cfg_ff.pitch_baseline[15]}}, cfg_ff.pitch_baseline};
         RegLevel: prdata = {17'd0, cfg_ff.level_band};
         RegNear: prdata = {17'd0, cfg_ff.near_band};
         RegPulse: prdata = {17'd0, cfg_ff.pulse_band};
         RegAlpha: prdata = {16'd0, cfg_ff.filter_alpha};
         default: prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{roll_baseline: 16'sd0, pitch_baseline: 16'sd0, level_band: 15'd1,
                     near_band: 15'd10, pulse_band: 15'd30, filter_alpha: 16'd6554};
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/tald_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tald_cordic
   import tald_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               start,
   input  wire logic signed [16:0] ny,
   input  wire logic signed [16:0] nx,
   output logic                    done,
   output logic signed [31:0]      angle
);
   localparam int Steps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;

   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0] z_ff, z_in;
   logic [4:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic zero_ff, zero_in;
   logic signed [33:0] dx, dy, x0, y0;

   assign x0 = {{3{nx[16]}}, nx, 14'd0};
   assign y0 = {{3{ny[16]}}, ny, 14'd0};
   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;
   assign angle = z_ff;
   assign done = busy_ff && (step_ff == 5'(Steps - 1));

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      if (start) begin
         step_in = 5'd0;
         busy_in = 1'b1;
         zero_in = 1'b0;
         if (nx == 17'sd0 && ny == 17'sd0) begin
            x_in = 34'sd0;
            y_in = 34'sd0;
            z_in = 32'sd0;
            zero_in = 1'b1;
         end else if (nx < 0) begin
            x_in = -x0;
            y_in = -y0;
            z_in = (ny >= 0) ? 32'sd11796480 : -32'sd11796480;
         end else begin
            x_in = x0;
            y_in = y0;
            z_in = 32'sd0;
         end
      end else if (busy_ff) begin
         if (!zero_ff) begin
            if (y_ff >= 0) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_entry(step_ff);
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_entry(step_ff);
            end
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(Steps - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      step_ff <= step_in;
      busy_ff <= busy_in;
      zero_ff <= zero_in;
   end
endmodule
`default_nettype wire

// ===== src/tilt_angle_level_detector_core.sv =====
// Tilt angle level detector. Each word on the req channel carries one raw
// X/Y/Z accelerometer sample; the rsp channel returns one word per sample with
// the averaged roll and pitch deviations from the baselines and the level,
// near, pulse and sticky tilt-sign flags for each axis.
// The csr port is an APB-style register port; write registers only while idle.
// One sample is handled at a time. The squares of the three axes are summed,
// the square root is found bit pair by bit pair, and each of the two
// arctangents runs through start, rotation, scaling and filtering on one shared
// rotator. The ring is then updated in a read and a sum state, and each axis
// then runs a restoring divide by WINDOW and a flag evaluation.
// After reset the ring memory is cleared one entry per cycle while req ready
// stays low. The result word is held in an output register; a stalled receiver
// holds it and the block waits before taking the next sample.
`timescale 1ns / 1ps
`default_nettype none
module tilt_angle_level_detector_core
   import tald_pkg::*;
#(
   parameter int WINDOW = 130,
   parameter int ANGLE_SCALE = 100,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   tald_req_if.sink         req,
   tald_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int SlotW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   cfg_type cfg;
   state_type state_ff, state_in;

   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic [31:0] sq_ff, sq_in;
   logic [1:0] phase_ff, phase_in;
   logic [31:0] rem_ff, rem_in;
   logic [16:0] root_ff, root_in;
   logic [4:0] cnt_ff, cnt_in;
   logic signed [31:0] roll_now_ff, pitch_now_ff;
   logic signed [15:0] roll_filt_ff, pitch_filt_ff;
   logic signed [23:0] roll_sum_ff, pitch_sum_ff;
   logic [SlotW-1:0] slot_ff;
   logic [SlotW-1:0] clr_ff;
   logic roll_held_ff, pitch_held_ff;
   logic signed [15:0] roll_old_ff, pitch_old_ff;
   logic [23:0] quot_ff;
   logic [24:0] drem_ff;
   logic [23:0] dnum_ff;
   logic signed [15:0] rdev_ff, pdev_ff;
   logic rsp_valid_ff;
   logic roll_lvl_ff, roll_near_ff, roll_pulse_ff;
   logic pitch_lvl_ff, pitch_near_ff, pitch_pulse_ff;
   logic signed [15:0] roll_mem [WINDOW];
   logic signed [15:0] pitch_mem [WINDOW];

   logic cord_start, cord_done;
   logic signed [16:0] cord_y, cord_x;
   logic signed [31:0] cord_angle;
   logic signed [31:0] sq_term;
   logic signed [47:0] scaled;
   logic signed [31:0] scaled_q;
   logic signed [33:0] lp_acc;
   logic signed [15:0] lp_q;
   logic [24:0] dtry;
   logic signed [23:0] avg_s;
   logic signed [17:0] dev_w;
   logic signed [15:0] dev_sat;
   logic signed [16:0] mag;
   logic axis_ff;
   logic signed [23:0] roll_sum_new;
   logic take;

   tald_csr u_csr (
      .clock(clock), .reset(reset), .psel(csr_psel), .penable(csr_penable),
      .pwrite(csr_pwrite), .paddr(csr_paddr), .pwdata(csr_pwdata),
      .prdata(csr_prdata), .pready(csr_pready), .cfg(cfg)
   );

   tald_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .start(cord_start), .ny(cord_y), .nx(cord_x),
      .done(cord_done), .angle(cord_angle)
   );

   assign take = (state_ff == ST_IDLE) && req.valid && !rsp_valid_ff;
   assign roll_sum_new = roll_sum_ff - 24'(roll_old_ff) + 24'(roll_filt_ff);

   // Shared arithmetic, selected by the current axis (the square term by the sum phase).
   always_comb begin
      case (phase_ff)
         2'd0: sq_term = ax_ff * ax_ff;
         2'd1: sq_term = ay_ff * ay_ff;
         default: sq_term = az_ff * az_ff;
      endcase
      cord_start = (state_ff == ST_PREP);
      cord_y = axis_ff ? 17'(ay_ff) : 17'(ax_ff);
      cord_x = axis_ff ? 17'(az_ff) : {1'b0, root_ff[15:0]};
      scaled = (axis_ff ? (cord_angle - 32'sd5898240) : cord_angle) * 48'(ANGLE_SCALE);
      scaled_q = (scaled < 0) ? -32'((-scaled) >>> 16) : 32'(scaled >>> 16);
      lp_acc = axis_ff
         ? $signed({1'b0, cfg.filter_alpha}) * 34'(pitch_now_ff)
           + $signed(18'd65536 - {2'd0, cfg.filter_alpha}) * 34'(pitch_filt_ff)
         : $signed({1'b0, cfg.filter_alpha}) * 34'(roll_now_ff)
           + $signed(18'd65536 - {2'd0, cfg.filter_alpha}) * 34'(roll_filt_ff);
      lp_q = (lp_acc < 0) ? -16'((-lp_acc) >>> 16) : 16'(lp_acc >>> 16);
      dtry = {drem_ff[23:0], dnum_ff[23]} - 25'(WINDOW);
      avg_s = (axis_ff ? pitch_sum_ff[23] : roll_sum_ff[23]) ? -$signed(quot_ff)
                                                           : $signed(quot_ff);
      dev_w = 18'(avg_s) - 18'(axis_ff ? cfg.pitch_baseline : cfg.roll_baseline);
      dev_sat = (dev_w > 18'sd32767) ? 16'sh7fff :
                (dev_w < -18'sd32768) ? 16'sh8000 : dev_w[15:0];
      mag = (dev_sat < 0) ? -17'(dev_sat) : 17'(dev_sat);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == SlotW'(WINDOW - 1)) state_in = ST_IDLE;
         ST_IDLE: if (req.valid && !rsp_valid_ff) state_in = ST_SQUARE;
         ST_SQUARE: if (phase_ff == 2'd2) state_in = ST_ROOT;
         ST_ROOT: if (cnt_ff == 5'd15) state_in = ST_PREP;
         ST_PREP: state_in = ST_ROTATE;
         ST_ROTATE: if (cord_done) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_FILTER;
         ST_FILTER: state_in = axis_ff ? ST_READ : ST_PREP;
         ST_READ: state_in = ST_SUM;
         ST_SUM: state_in = ST_DIVIDE;
         ST_DIVIDE: if (cnt_ff == 5'd23) state_in = ST_JUDGE;
         ST_JUDGE: state_in = axis_ff ? ST_IDLE : ST_DIVIDE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
      sq_in = sq_ff;
      phase_in = phase_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      if (take) begin
         sq_in = 32'd0;
         phase_in = 2'd0;
      end else if (state_ff == ST_SQUARE) begin
         sq_in = sq_ff + 32'(sq_term);
         phase_in = phase_ff + 2'd1;
         cnt_in = 5'd0;
         rem_in = 32'd0;
         root_in = 17'd0;
      end else if (state_ff == ST_ROOT) begin
         rem_in = {rem_ff[29:0], sq_ff[31:30]};
         root_in = {root_ff[15:0], 1'b0};
         if ({rem_ff[29:0], sq_ff[31:30]} >= ({13'd0, root_ff, 2'b01})) begin
            rem_in = {rem_ff[29:0], sq_ff[31:30]} - {13'd0, root_ff, 2'b01};
            root_in = {root_ff[15:0], 1'b1};
         end
         sq_in = {sq_ff[29:0], 2'b00};
         cnt_in = cnt_ff + 5'd1;
      end else if (state_ff == ST_SUM || state_ff == ST_JUDGE) begin
         cnt_in = 5'd0;
      end else if (state_ff == ST_DIVIDE) begin
         cnt_in = cnt_ff + 5'd1;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.roll_deviation = rdev_ff;
   assign rsp.pitch_deviation = pdev_ff;
   assign rsp.roll_is_level = roll_lvl_ff;
   assign rsp.roll_is_near = roll_near_ff;
   assign rsp.roll_wants_pulse = roll_pulse_ff;
   assign rsp.roll_tilt_positive = roll_held_ff;
   assign rsp.pitch_is_level = pitch_lvl_ff;
   assign rsp.pitch_is_near = pitch_near_ff;
   assign rsp.pitch_wants_pulse = pitch_pulse_ff;
   assign rsp.pitch_tilt_positive = pitch_held_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         roll_mem[clr_ff] <= 16'sd0;
         pitch_mem[clr_ff] <= 16'sd0;
      end else if (state_ff == ST_SUM) begin
         roll_mem[slot_ff] <= roll_filt_ff;
         pitch_mem[slot_ff] <= pitch_filt_ff;
      end
      if (state_ff == ST_READ) begin
         roll_old_ff <= roll_mem[slot_ff];
         pitch_old_ff <= pitch_mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         slot_ff <= '0;
         roll_filt_ff <= '0;
         pitch_filt_ff <= '0;
         roll_sum_ff <= '0;
         pitch_sum_ff <= '0;
         roll_held_ff <= 1'b0;
         pitch_held_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         axis_ff <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         sq_ff <= sq_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + SlotW'(1);
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         if (take) begin
            axis_ff <= 1'b0;
         end
         if (state_ff == ST_SCALE) begin
            if (axis_ff) pitch_now_ff <= scaled_q;
            else roll_now_ff <= scaled_q;
         end
         if (state_ff == ST_FILTER) begin
            if (axis_ff) pitch_filt_ff <= lp_q;
            else begin
               roll_filt_ff <= lp_q;
               axis_ff <= 1'b1;
            end
         end
         if (state_ff == ST_SUM) begin
            roll_sum_ff <= roll_sum_new;
            pitch_sum_ff <= pitch_sum_ff - 24'(pitch_old_ff) + 24'(pitch_filt_ff);
            slot_ff <= (slot_ff == SlotW'(WINDOW - 1)) ? '0 : slot_ff + SlotW'(1);
            axis_ff <= 1'b0;
         end
         if (state_ff == ST_JUDGE) begin
            if (axis_ff) begin
               pdev_ff <= dev_sat;
               pitch_lvl_ff <= mag <= 17'(cfg.level_band);
               pitch_near_ff <= (mag > 17'(cfg.level_band)) && (mag <= 17'(cfg.near_band));
               pitch_pulse_ff <= mag <= 17'(cfg.pulse_band);
               if (dev_sat > $signed(17'(cfg.level_band))) pitch_held_ff <= 1'b1;
               else if (dev_sat < -$signed(17'(cfg.level_band))) pitch_held_ff <= 1'b0;
               rsp_valid_ff <= 1'b1;
               axis_ff <= 1'b0;
            end else begin
               rdev_ff <= dev_sat;
               roll_lvl_ff <= mag <= 17'(cfg.level_band);
               roll_near_ff <= (mag > 17'(cfg.level_band)) && (mag <= 17'(cfg.near_band));
               roll_pulse_ff <= mag <= 17'(cfg.pulse_band);
               if (dev_sat > $signed(17'(cfg.level_band))) roll_held_ff <= 1'b1;
               else if (dev_sat < -$signed(17'(cfg.level_band))) roll_held_ff <= 1'b0;
               axis_ff <= 1'b1;
            end
         end
      end
   end

   // Sample capture, root registers and restoring divide of |sum| by WINDOW, one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req.valid) begin
         ax_ff <= req.accel_x;
         ay_ff <= req.accel_y;
         az_ff <= req.accel_z;
      end
      rem_ff <= rem_in;
      root_ff <= root_in;
      cnt_ff <= cnt_in;
      if (state_ff == ST_SUM || state_ff == ST_JUDGE) begin
         drem_ff <= 25'd0;
         quot_ff <= 24'd0;
         if (state_ff == ST_SUM) begin
            dnum_ff <= (roll_sum_new < 0) ? 24'(-roll_sum_new) : 24'(roll_sum_new);
         end else begin
            dnum_ff <= pitch_sum_ff[23] ? 24'(-pitch_sum_ff) : 24'(pitch_sum_ff);
         end
      end else if (state_ff == ST_DIVIDE) begin
         dnum_ff <= {dnum_ff[22:0], 1'b0};
         if (!dtry[24]) begin
            drem_ff <= dtry;
            quot_ff <= {quot_ff[22:0], 1'b1};
         end else begin
            drem_ff <= {drem_ff[23:0], dnum_ff[23]};
            quot_ff <= {quot_ff[22:0], 1'b0};
         end
      end
   end
endmodule
`default_nettype wire

// ===== src/tald_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tald_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic roll_is_level,
   input wire logic roll_is_near,
   input wire logic pitch_is_level,
   input wire logic pitch_is_near
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp word dropped");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("sample taken while word pending");
   a_roll_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(roll_is_level && roll_is_near)) else $error("roll flags overlap");
   a_pitch_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(pitch_is_level && pitch_is_near)) else $error("pitch flags overlap");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("rsp valid after reset");
endmodule

bind tilt_angle_level_detector_core tald_checker u_tald_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .roll_is_level(rsp.roll_is_level), .roll_is_near(rsp.roll_is_near),
   .pitch_is_level(rsp.pitch_is_level), .pitch_is_near(rsp.pitch_is_near)
);
`default_nettype wire
